[rtl/wsd_pkg.sv]
package wsd_pkg;

	localparam int SAMPLE_BITS = 10;
	localparam int SUM_BITS    = SAMPLE_BITS + 2;
	localparam int TIME_BITS   = 32;
	localparam int WIN_BITS    = 16;
	localparam int BOUND_BITS  = 12;
	localparam int AXES        = 3;

	localparam int IN_BITS     = TIME_BITS + AXES * SAMPLE_BITS;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = AXES * SAMPLE_BITS + SUM_BITS + 2;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam int ADDR_BITS   = 4;
	localparam int DATA_BITS   = 32;

	typedef logic [SAMPLE_BITS-1:0] code_t;
	typedef logic [SUM_BITS-1:0]    sum_t;

	typedef enum logic [1:0] {
		REG_WINDOW_MS  = 2'd0,
		REG_SWING_LOW  = 2'd1,
		REG_SWING_HIGH = 2'd2
	} reg_idx_t;

	localparam logic [WIN_BITS-1:0]   WINDOW_MS_RST  = WIN_BITS'(100);
	localparam logic [BOUND_BITS-1:0] SWING_LOW_RST  = BOUND_BITS'(103);
	localparam logic [BOUND_BITS-1:0] SWING_HIGH_RST = BOUND_BITS'(308);
	localparam code_t CODE_MID = code_t'(1 << (SAMPLE_BITS - 1));

	typedef struct packed {
		logic [WIN_BITS-1:0]   window_ms;
		logic [BOUND_BITS-1:0] swing_low;
		logic [BOUND_BITS-1:0] swing_high;
	} cfg_t;

endpackage

[rtl/wsd_cfg.sv]
module wsd_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [wsd_pkg::ADDR_BITS-1:0]   paddr,
	input  logic [wsd_pkg::DATA_BITS-1:0]   pwdata,
	output logic [wsd_pkg::DATA_BITS-1:0]   prdata,
	output logic                            pready,
	output wsd_pkg::cfg_t                   cfg
);

	wsd_pkg::cfg_t    cfg_q;
	wsd_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = wsd_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_ms  <= wsd_pkg::WINDOW_MS_RST;
			cfg_q.swing_low  <= wsd_pkg::SWING_LOW_RST;
			cfg_q.swing_high <= wsd_pkg::SWING_HIGH_RST;
		end else if (wr_en) begin
			unique case (idx)
				wsd_pkg::REG_WINDOW_MS: begin
					cfg_q.window_ms <= pwdata[wsd_pkg::WIN_BITS-1:0];
				end
				wsd_pkg::REG_SWING_LOW: begin
					cfg_q.swing_low <= pwdata[wsd_pkg::BOUND_BITS-1:0];
				end
				wsd_pkg::REG_SWING_HIGH: begin
					cfg_q.swing_high <= pwdata[wsd_pkg::BOUND_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			wsd_pkg::REG_WINDOW_MS: begin
				prdata = wsd_pkg::DATA_BITS'(cfg_q.window_ms);
			end
			wsd_pkg::REG_SWING_LOW: begin
				prdata = wsd_pkg::DATA_BITS'(cfg_q.swing_low);
			end
			wsd_pkg::REG_SWING_HIGH: begin
				prdata = wsd_pkg::DATA_BITS'(cfg_q.swing_high);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

[rtl/wsd_axis.sv]
module wsd_axis (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           upd,
	input  logic           closed,
	input  wsd_pkg::code_t code,
	output wsd_pkg::code_t range_nxt
);

	wsd_pkg::code_t min_q, max_q, range_q;
	wsd_pkg::code_t min_base, max_base;

	assign min_base  = closed ? code : min_q;
	assign max_base  = closed ? code : max_q;
	assign range_nxt = closed ? wsd_pkg::code_t'(max_q - min_q) : range_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= wsd_pkg::CODE_MID;
			max_q   <= wsd_pkg::CODE_MID;
			range_q <= '0;
		end else if (upd) begin
			min_q   <= (code < min_base) ? code : min_base;
			max_q   <= (code > max_base) ? code : max_base;
			range_q <= range_nxt;
		end
	end

endmodule

[rtl/windowed_swing_detector.sv]
// Peak-to-peak window detector for a 3-axis accelerometer working on raw ADC
// codes. Each request carries a wrapping millisecond timestamp and one code
// per axis; each yields exactly one result. When the time since the window
// start exceeds window_ms, the per-axis ranges (max minus min) are latched,
// min and max restart at the current sample and the window restarts at this
// timestamp. Results give the latched ranges, their sum, a flag that the sum
// lies in [swing_low_codes, swing_high_codes) and a flag that the window
// closed on this sample. The block takes one request per clock while the
// output is not stalled and passes it through one input register and one
// result register, with all window and range logic between them. Registers
// sit at byte addresses 0 (window_ms), 4 (swing_low_codes) and 8
// (swing_high_codes) and must be written only while no request is in flight.
module windowed_swing_detector (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [wsd_pkg::ADDR_BITS-1:0]     paddr,
	input  logic [wsd_pkg::DATA_BITS-1:0]     pwdata,
	output logic [wsd_pkg::DATA_BITS-1:0]     prdata,
	output logic                              pready,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// now_ms, x_code, y_code, z_code
	input  logic [wsd_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// x_range, y_range, z_range, range_sum, swinging, window_closed
	output logic [wsd_pkg::OUT_TDATA_W-1:0]   m_tdata
);

	localparam int SB = wsd_pkg::SAMPLE_BITS;
	localparam int TB = wsd_pkg::TIME_BITS;

	wsd_pkg::cfg_t cfg;

	logic                         valid_s1;
	logic [TB-1:0]                now_s1;
	wsd_pkg::code_t               code_s1 [wsd_pkg::AXES];
	logic [TB-1:0]                window_start_q;
	logic                         adv_s1, free_s2, closed;
	logic [TB-1:0]                elapsed;
	wsd_pkg::code_t               range_nxt [wsd_pkg::AXES];
	wsd_pkg::sum_t                sum;
	logic                         swinging;
	logic                         valid_s2;
	logic [wsd_pkg::OUT_BITS-1:0] result_s2;

	wsd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign free_s2  = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && free_s2;
	assign s_tready = !valid_s1 || free_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			now_s1 <= s_tdata[TB-1:0];
			for (int a = 0; a < wsd_pkg::AXES; a++) begin
				code_s1[a] <= s_tdata[TB + a*SB +: SB];
			end
		end
	end

	assign elapsed = now_s1 - window_start_q;
	assign closed  = elapsed > TB'(cfg.window_ms);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_start_q <= '0;
		end else if (adv_s1 && closed) begin
			window_start_q <= now_s1;
		end
	end

	for (genvar a = 0; a < wsd_pkg::AXES; a++) begin : g_axis
		wsd_axis u_axis (
			.clk       (clk),
			.arst_n    (arst_n),
			.upd       (adv_s1),
			.closed    (closed),
			.code      (code_s1[a]),
			.range_nxt (range_nxt[a])
		);
	end

	assign sum = wsd_pkg::sum_t'(range_nxt[0]) + wsd_pkg::sum_t'(range_nxt[1])
		+ wsd_pkg::sum_t'(range_nxt[2]);
	assign swinging = (TB'(sum) >= TB'(cfg.swing_low))
		&& (TB'(sum) < TB'(cfg.swing_high));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2 <= {closed, swinging, sum, range_nxt[2], range_nxt[1], range_nxt[0]};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = wsd_pkg::OUT_TDATA_W'(result_s2);

endmodule

[rtl/wsd_checker.sv]
module wsd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            pready,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [wsd_pkg::OUT_TDATA_W-1:0] m_tdata
);

	localparam int SB = wsd_pkg::SAMPLE_BITS;

	wsd_pkg::sum_t field_sum, calc_sum;

	assign field_sum = m_tdata[3*SB +: wsd_pkg::SUM_BITS];
	assign calc_sum  = wsd_pkg::sum_t'(m_tdata[0 +: SB]) + wsd_pkg::sum_t'(m_tdata[SB +: SB])
		+ wsd_pkg::sum_t'(m_tdata[2*SB +: SB]);

	// A stalled result must hold still until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// The sum field of a valid result always matches the three range fields.
	a_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> field_sum == calc_sum)
		else $error("range_sum does not match ranges");

	// An empty result register never blocks new requests.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// The configuration port never inserts wait states.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind windowed_swing_detector wsd_checker u_wsd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.pready   (pready),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
